// ===== hdl/dcpa_pkg.sv =====
package dcpa_pkg;

    // Reorder buffer ring size; tags and the head index are 5-bit fields.
    localparam int ROB_DEPTH = 32;
    localparam int TAG_W     = $clog2(ROB_DEPTH);

    // Input word opcodes.
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_LOAD_UPD   = 2'd1;
    localparam logic [1:0] OP_STORE_UPD  = 2'd2;
    localparam logic [1:0] OP_COMMIT_UPD = 2'd3;

    // Memory opcodes that make a byte access; everything else is 8 bytes.
    localparam logic [7:0] MEM_OP_BYTE_A = 8'h50;
    localparam logic [7:0] MEM_OP_BYTE_B = 8'h51;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd3;

    // Hazards are checked on aligned 8-byte words.
    localparam int WORD_LSB = 3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [1:0]       slot;
        logic             valid_req;
        logic [63:0]      address;
        logic [63:0]      data;
        logic [TAG_W-1:0] rob_tag;
        logic [7:0]       mem_op;
        logic [TAG_W-1:0] rob_head;
        logic             flush;
        logic             cache_ready;
        logic             cache_done;
    } t_in_word;

    typedef struct packed {
        logic        done_valid;
        logic [1:0]  done_target;
        logic [63:0] read_data;
        logic        issue_valid;
        logic        issue_write;
        logic [63:0] issue_address;
        logic [63:0] write_data;
        logic [1:0]  access_size;
        logic [1:0]  issue_source;
    } t_out_word;

    typedef struct packed {
        logic             pending;
        logic [63:0]      address;
        logic [TAG_W-1:0] tag;
        logic [7:0]       mem_op;
    } t_load_entry;

    typedef struct packed {
        logic             addr_ready;
        logic [63:0]      address;
        logic [TAG_W-1:0] tag;
    } t_store_entry;

    typedef struct packed {
        logic        pending;
        logic [63:0] address;
        logic [63:0] data;
        logic [7:0]  mem_op;
    } t_commit_entry;

    // Access the grant logic would issue if the port were free.
    typedef struct packed {
        logic        valid;
        logic        write;
        logic [63:0] address;
        logic [63:0] write_data;
        logic [1:0]  access_size;
    } t_issue;

    function automatic logic [1:0] size_of_op(input logic [7:0] op);
        logic [1:0] size;
        size = SIZE_WORD;
        if (op == MEM_OP_BYTE_A || op == MEM_OP_BYTE_B) begin
            size = SIZE_BYTE;
        end
        return size;
    endfunction

    // Distance from the head in the ring; the 5-bit subtraction wraps modulo the depth.
    function automatic logic [TAG_W-1:0] age_of(input logic [TAG_W-1:0] tag,
                                                input logic [TAG_W-1:0] head);
        return tag - head;
    endfunction

endpackage

// ===== hdl/dcpa_req_state.sv =====
module dcpa_req_state #(
    parameter int LOAD_PORTS    = 3,
    parameter int STORE_ENTRIES = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_upd_en,
    input  dcpa_pkg::t_in_word     i_word,
    output dcpa_pkg::t_load_entry  o_load  [LOAD_PORTS],
    output dcpa_pkg::t_store_entry o_store [STORE_ENTRIES],
    output dcpa_pkg::t_commit_entry o_commit
);
    import dcpa_pkg::*;

    t_load_entry   r_load   [LOAD_PORTS];
    t_store_entry  r_store  [STORE_ENTRIES];
    t_commit_entry r_commit;

    // Only the flags need a reset; the rest of an entry is read only while its flag is set.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LOAD_PORTS; k++) begin
            if (i_upd_en && i_word.opcode == OP_LOAD_UPD && int'(i_word.slot) == k) begin
                r_load[k].pending <= i_word.valid_req;
                r_load[k].address <= i_word.address;
                r_load[k].tag     <= i_word.rob_tag;
                r_load[k].mem_op  <= i_word.mem_op;
            end
            if (!i_rst_n) begin
                r_load[k].pending <= 1'b0;
            end
        end
        for (int s = 0; s < STORE_ENTRIES; s++) begin
            if (i_upd_en && i_word.opcode == OP_STORE_UPD && int'(i_word.slot) == s) begin
                r_store[s].addr_ready <= i_word.valid_req;
                r_store[s].address    <= i_word.address;
                r_store[s].tag        <= i_word.rob_tag;
            end
            if (!i_rst_n) begin
                r_store[s].addr_ready <= 1'b0;
            end
        end
        if (i_upd_en && i_word.opcode == OP_COMMIT_UPD) begin
            r_commit.pending <= i_word.valid_req;
            r_commit.address <= i_word.address;
            r_commit.data    <= i_word.data;
            r_commit.mem_op  <= i_word.mem_op;
        end
        if (!i_rst_n) begin
            r_commit.pending <= 1'b0;
        end
    end

    assign o_load   = r_load;
    assign o_store  = r_store;
    assign o_commit = r_commit;

endmodule

// ===== hdl/dcpa_grant.sv =====
module dcpa_grant #(
    parameter int LOAD_PORTS    = 3,
    parameter int STORE_ENTRIES = 2,
    parameter int OWNER_W       = 2
) (
    input  dcpa_pkg::t_load_entry   i_load  [LOAD_PORTS],
    input  dcpa_pkg::t_store_entry  i_store [STORE_ENTRIES],
    input  dcpa_pkg::t_commit_entry i_commit,
    input  logic [dcpa_pkg::TAG_W-1:0] i_head,
    output dcpa_pkg::t_issue        o_issue,
    output logic [OWNER_W-1:0]      o_owner
);
    import dcpa_pkg::*;

    logic [LOAD_PORTS-1:0] hazard;
    logic [LOAD_PORTS-1:0] eligible;

    // A load waits while an older store with a known address covers its 8-byte word.
    always_comb begin
        for (int k = 0; k < LOAD_PORTS; k++) begin
            hazard[k] = 1'b0;
            for (int s = 0; s < STORE_ENTRIES; s++) begin
                if (i_store[s].addr_ready
                    && i_store[s].address[63:WORD_LSB] == i_load[k].address[63:WORD_LSB]
                    && age_of(i_store[s].tag, i_head) < age_of(i_load[k].tag, i_head)) begin
                    hazard[k] = 1'b1;
                end
            end
            eligible[k] = i_load[k].pending && !hazard[k];
        end
    end

    always_comb begin
        o_issue = '0;
        o_owner = '0;
        if (i_commit.pending) begin
            o_issue.valid       = 1'b1;
            o_issue.write       = 1'b1;
            o_issue.address     = i_commit.address;
            o_issue.write_data  = i_commit.data;
            o_issue.access_size = size_of_op(i_commit.mem_op);
        end else begin
            // Walk from the highest slot down so the lowest eligible slot wins.
            for (int k = LOAD_PORTS - 1; k >= 0; k--) begin
                if (eligible[k]) begin
                    o_issue.valid       = 1'b1;
                    o_issue.write       = 1'b0;
                    o_issue.address     = i_load[k].address;
                    o_issue.write_data  = '0;
                    o_issue.access_size = size_of_op(i_load[k].mem_op);
                    o_owner             = OWNER_W'(k + 1);
                end
            end
        end
    end

endmodule

// ===== hdl/dcache_port_arbiter_with_store_hazard.sv =====
// Single-port data-cache arbiter. Update words (load slot, store buffer entry, committed
// store) set held request state and return nothing; each tick word returns one result word
// that routes a cache completion to the port owner and then issues at most one new access,
// committed store first, then load slots from 0 upward, holding back any load that an older
// address-ready store hits in the same aligned 8-byte word. A flush cancels an in-flight
// load, keeps an in-flight store, and routes and issues nothing. The block takes one word
// every cycle unless the input side is stalled; a tick word is held in the input register,
// where the grant and hazard compare are done in a single pass, and then lands in the
// result register. A stalled result register holds the input side only when a tick word
// is waiting behind it.
module dcache_port_arbiter_with_store_hazard #(
    parameter int LOAD_PORTS    = 3,
    parameter int STORE_ENTRIES = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dcpa_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dcpa_pkg::t_out_word o_out_word
);
    import dcpa_pkg::*;

    localparam int OWNER_W = $clog2(LOAD_PORTS + 1);

    logic                r_in_valid;
    t_in_word            r_in;
    logic                r_busy;
    logic [OWNER_W-1:0]  r_owner;
    logic                r_out_valid;
    t_out_word           r_out;

    logic                n_busy;
    logic [OWNER_W-1:0]  n_owner;
    t_out_word           n_out;

    logic                is_tick;
    logic                out_free;
    logic                proc_fire;
    logic                busy_after_done;

    t_load_entry         load_q   [LOAD_PORTS];
    t_store_entry        store_q  [STORE_ENTRIES];
    t_commit_entry       commit_q;
    t_issue              grant;
    logic [OWNER_W-1:0]  grant_owner;

    assign is_tick    = (r_in.opcode == OP_TICK);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_fire  = r_in_valid && (!is_tick || out_free);
    assign o_in_stall = r_in_valid && !proc_fire;

    dcpa_req_state #(
        .LOAD_PORTS    (LOAD_PORTS),
        .STORE_ENTRIES (STORE_ENTRIES)
    ) u_req_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd_en (proc_fire),
        .i_word   (r_in),
        .o_load   (load_q),
        .o_store  (store_q),
        .o_commit (commit_q)
    );

    dcpa_grant #(
        .LOAD_PORTS    (LOAD_PORTS),
        .STORE_ENTRIES (STORE_ENTRIES),
        .OWNER_W       (OWNER_W)
    ) u_grant (
        .i_load   (load_q),
        .i_store  (store_q),
        .i_commit (commit_q),
        .i_head   (r_in.rob_head),
        .o_issue  (grant),
        .o_owner  (grant_owner)
    );

    always_comb begin
        n_out           = '0;
        n_busy          = r_busy;
        n_owner         = r_owner;
        busy_after_done = r_busy && !r_in.cache_done;
        if (r_in.flush) begin
            // Owner zero is the committed store, which stays in flight.
            if (r_busy && r_owner != '0) begin
                n_busy  = 1'b0;
                n_owner = '0;
            end
        end else begin
            if (r_busy && r_in.cache_done) begin
                n_out.done_valid  = 1'b1;
                n_out.done_target = 2'(r_owner);
                n_out.read_data   = (r_owner != '0) ? r_in.data : '0;
                n_busy            = 1'b0;
                n_owner           = '0;
            end
            if (!busy_after_done && r_in.cache_ready && grant.valid) begin
                n_out.issue_valid   = 1'b1;
                n_out.issue_write   = grant.write;
                n_out.issue_address = grant.address;
                n_out.write_data    = grant.write_data;
                n_out.access_size   = grant.access_size;
                n_out.issue_source  = 2'(grant_owner);
                n_busy              = 1'b1;
                n_owner             = grant_owner;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_word;
        end
        if (out_free) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_owner     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= proc_fire && is_tick;
            end
            if (proc_fire && is_tick) begin
                r_busy  <= n_busy;
                r_owner <= n_owner;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
